// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds the control state encoding, command and character codes, and word widths.
// No dependencies.
`default_nettype none

package tcw_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tcw_state_t;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = 12;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

endpackage

`default_nettype wire

// ===== hdl/tcw_cursor.sv =====
// Cursor update for one put command: control codes, advance, and scroll detection.
// Depends on tcw_pkg for the character codes.
`default_nettype none

module tcw_cursor #(
  parameter int ROW_CELLS    = 128,
  parameter int SCREEN_CELLS = 4096
) (
  input  wire logic [$clog2(SCREEN_CELLS+1)-1:0] cursor,
  input  wire logic [$clog2(ROW_CELLS)-1:0]      col,
  input  wire logic [tcw_pkg::CHAR_W-1:0]        character,
  output logic      [$clog2(SCREEN_CELLS+1)-1:0] cursor_nxt,
  output logic      [$clog2(ROW_CELLS)-1:0]      col_nxt,
  output logic                                   store,
  output logic                                   scroll
);
  import tcw_pkg::*;

  localparam int CW = $clog2(SCREEN_CELLS + 1);
  localparam int COLW = $clog2(ROW_CELLS);
  localparam int SCROLL_CUR = SCREEN_CELLS - 2 * ROW_CELLS;
  localparam int SCROLL_COL = SCROLL_CUR % ROW_CELLS;

  logic [CW-1:0]   cur_tmp;
  logic [COLW-1:0] col_tmp;

  always_comb begin
    cur_tmp = cursor;
    col_tmp = col;
    store   = 1'b0;
    case (character) inside
      CH_BS, CH_DEL: begin
        if (col != '0) begin
          cur_tmp = cursor - CW'(1);
          col_tmp = col - COLW'(1);
        end
      end
      CH_CR: begin
        cur_tmp = cursor - CW'(col);
        col_tmp = '0;
      end
      CH_LF: begin
        cur_tmp = cursor - CW'(col) + CW'(ROW_CELLS);
        col_tmp = '0;
      end
      default: begin
        store   = 1'b1;
        cur_tmp = cursor + CW'(1);
        col_tmp = (col == COLW'(ROW_CELLS - 1)) ? '0 : col + COLW'(1);
      end
    endcase
    scroll = (cur_tmp >= CW'(SCREEN_CELLS - ROW_CELLS));
    if (scroll) begin
      cursor_nxt = CW'(SCROLL_CUR);
      col_nxt    = COLW'(SCROLL_COL);
    end else begin
      cursor_nxt = cur_tmp;
      col_nxt    = col_tmp;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Text console writer: a put gives its result in the cycle after acceptance; a read goes
// through the memory read register and ST_READ to its result. A put that scrolls walks
// the screen memory one cell per cycle on the single write port (copy of all rows but the
// first, then the space fill). After reset a clearing pass writes zero to every cell, with
// no words accepted. Depends on tcw_pkg and tcw_cursor.
`default_nettype none

module text_console_writer #(
  parameter int ROW_CELLS    = 128,
  parameter int SCREEN_CELLS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [7:0] character, [19:8] read_address, [23:20] zero
  input  wire logic [tcw_pkg::IN_W-1:0]    in_tdata,
  // [0] command
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [11:0] cursor_position, [12] scrolled, [20:13] read_data, [23:21] zero
  output logic      [tcw_pkg::OUT_W-1:0]   out_tdata
);
  import tcw_pkg::*;

  localparam int CW   = $clog2(SCREEN_CELLS + 1);
  localparam int COLW = $clog2(ROW_CELLS);
  localparam int AW   = $clog2(SCREEN_CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(SCREEN_CELLS - 1);

  tcw_state_t state_r, state_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [COLW-1:0]   col_r, col_nxt;
  logic [AW-1:0]     sc_r, sc_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic [CHAR_W-1:0] mem [SCREEN_CELLS];
  logic [CHAR_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  logic              in_fire;
  logic              cmd;
  logic [CHAR_W-1:0] in_char;
  logic [ADDR_W-1:0] in_addr;
  logic [CW-1:0]     cu_cursor;
  logic [COLW-1:0]   cu_col;
  logic              cu_store;
  logic              cu_scroll;

  function automatic logic [OUT_W-1:0] pack_out(input logic [CW-1:0] cur,
                                                input logic scr,
                                                input logic [CHAR_W-1:0] data);
    logic [ADDR_W-1:0] cur12;
    cur12 = ADDR_W'(32'(cur));
    return {3'b000, data, scr, cur12};
  endfunction

  assign cmd       = in_tuser;
  assign in_char   = in_tdata[7:0];
  assign in_addr   = in_tdata[19:8];
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  tcw_cursor #(
    .ROW_CELLS   (ROW_CELLS),
    .SCREEN_CELLS(SCREEN_CELLS)
  ) u_cursor (
    .cursor    (cursor_r),
    .col       (col_r),
    .character (in_char),
    .cursor_nxt(cu_cursor),
    .col_nxt   (cu_col),
    .store     (cu_store),
    .scroll    (cu_scroll)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sc_r == LAST_CELL) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_READ) begin
            state_nxt = ST_READ;
          end else if (cu_scroll) begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_COPY:  if (sc_r == LAST_CELL) state_nxt = ST_FILL;
      ST_FILL:  if (!pend_r && sc_r == LAST_CELL) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    sc_nxt         = sc_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    rd_ok_nxt      = rd_ok_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = sc_r;
    mem_wdata      = '0;
    mem_raddr      = AW'(32'(in_addr));
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        sc_nxt = (sc_r == LAST_CELL) ? '0 : sc_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          rd_ok_nxt = (32'(in_addr) < 32'(SCREEN_CELLS));
          if (cmd == CMD_PUT) begin
            mem_we     = cu_store;
            mem_waddr  = AW'(cursor_r);
            mem_wdata  = in_char;
            cursor_nxt = cu_cursor;
            col_nxt    = cu_col;
            if (cu_scroll) begin
              sc_nxt = AW'(ROW_CELLS);
            end else begin
              out_tvalid_nxt = 1'b1;
              out_tdata_nxt  = pack_out(cu_cursor, 1'b0, '0);
            end
          end
        end
      end
      ST_READ: begin
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = pack_out(cursor_r, 1'b0, rd_ok_r ? rd_data_r : '0);
      end
      ST_COPY: begin
        mem_raddr     = sc_r;
        mem_we        = pend_r;
        mem_waddr     = pend_addr_r;
        mem_wdata     = rd_data_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = sc_r - AW'(ROW_CELLS);
        sc_nxt = (sc_r == LAST_CELL) ? AW'(SCREEN_CELLS - ROW_CELLS) : sc_r + AW'(1);
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (pend_r) begin
          mem_waddr = pend_addr_r;
          mem_wdata = rd_data_r;
          pend_nxt  = 1'b0;
        end else begin
          mem_wdata = CH_SPACE;
          if (sc_r == LAST_CELL) begin
            sc_nxt         = '0;
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = pack_out(cursor_r, 1'b1, '0);
          end else begin
            sc_nxt = sc_r + AW'(1);
          end
        end
      end
      default: begin
        sc_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cursor_r     <= '0;
      col_r        <= '0;
      sc_r         <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      col_r        <= col_nxt;
      sc_r         <= sc_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < CW'(SCREEN_CELLS - ROW_CELLS))
    else $error("cursor reached the last row between words");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_READ) |-> !pend_r)
    else $error("copy write still pending outside a scroll");

  a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_PUT && !cu_scroll) |=> (out_tvalid_r && !out_tdata_r[12]))
    else $error("put without scroll gave no result in the next cycle");

  a_scroll_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && state_nxt == ST_IDLE) |=> (out_tvalid_r && out_tdata_r[12]))
    else $error("scroll finished without a scrolled result");

endmodule

`default_nettype wire

// ===== tb/sv/text_console_writer_test.sv =====
`timescale 1ns / 1ps
// Testbench for text_console_writer: drives put and read words over the input stream,
// predicts cursor, scroll flag and read data with a screen tracker, checks every result.
// Depends on tcw_pkg and the text_console_writer RTL.

module text_console_writer_test;
  import tcw_pkg::*;

  typedef struct packed {
    logic [11:0] cursor_position;
    logic        scrolled;
    logic [7:0]  read_data;
  } console_result_t;

  // Tracks the screen contents and cursor, and holds the results still to come back.
  class screen_tracker;
    localparam int ROW = 128;
    localparam int CELLS = 4096;

    logic [7:0]      cells[CELLS];
    int unsigned     cursor;
    console_result_t expected_results[$];
    int              errors;

    function new();
      foreach (cells[i]) cells[i] = 8'd0;
      cursor = 0;
      errors = 0;
    endfunction

    function void note_word(logic cmd, logic [7:0] ch, logic [11:0] addr);
      console_result_t res;
      int unsigned col;
      res = '0;
      if (cmd == CMD_READ) begin
        res.read_data = cells[addr];
      end else begin
        col = cursor % ROW;
        case (ch)
          CH_BS, CH_DEL: begin
            if (col != 0) cursor = cursor - 1;
          end
          CH_CR: begin
            cursor = cursor - col;
          end
          CH_LF: begin
            cursor = cursor - col + ROW;
          end
          default: begin
            cells[cursor] = ch;
            cursor = cursor + 1;
          end
        endcase
        if (cursor >= CELLS - ROW) begin
          for (int i = 0; i < CELLS - ROW; i++) cells[i] = cells[i + ROW];
          for (int i = CELLS - ROW; i < CELLS; i++) cells[i] = CH_SPACE;
          cursor = CELLS - 2 * ROW;
          res.scrolled = 1'b1;
        end
      end
      res.cursor_position = cursor[11:0];
      expected_results.push_back(res);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      if (errors <= 10)
        $display("ERROR at %0t: %s expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_word(logic [OUT_W-1:0] data);
      console_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR at %0t: unexpected result word %h", $time, data);
        return;
      end
      want = expected_results.pop_front();
      if (data[11:0] !== want.cursor_position)
        report("cursor_position", int'(want.cursor_position), int'(data[11:0]));
      if (data[12] !== want.scrolled)
        report("scrolled", int'(want.scrolled), int'(data[12]));
      if (data[20:13] !== want.read_data)
        report("read_data", int'(want.read_data), int'(data[20:13]));
      if (data[23:21] !== 3'b000)
        report("padding", 0, int'(data[23:21]));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // [7:0] character, [19:8] read_address, [23:20] zero
  logic [IN_W-1:0]  in_tdata = '0;
  // [0] command
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [11:0] cursor_position, [12] scrolled, [20:13] read_data, [23:21] zero
  logic [OUT_W-1:0] out_tdata;

  screen_tracker sb = new();
  int  burst_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  text_console_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_word(in_tuser, in_tdata[7:0], in_tdata[19:8]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata);
  end

  task automatic send_word(input logic cmd, input logic [7:0] ch, input logic [11:0] addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, addr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Receiver: stretches of steady, random, sparse and alternating readiness, plus one long hold-off.
  initial begin
    int mode;
    int len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 60);
      repeat (len) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_tready <= 1'b0;
          repeat (600) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  initial begin
    int unsigned r;
    logic [7:0]  ch;
    logic [11:0] addr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_PUT, CH_BS, 12'd0);
    send_word(CMD_PUT, CH_DEL, 12'hfff);
    send_word(CMD_PUT, CH_CR, 12'd0);
    send_word(CMD_PUT, 8'd65, 12'd0);
    send_word(CMD_PUT, 8'd0, 12'd0);
    send_word(CMD_PUT, 8'd255, 12'd0);
    send_word(CMD_PUT, 8'd66, 12'd0);
    send_word(CMD_PUT, CH_BS, 12'd0);
    send_word(CMD_PUT, CH_DEL, 12'd0);
    send_word(CMD_READ, 8'd0, 12'd0);
    send_word(CMD_READ, 8'hff, 12'd1);
    send_word(CMD_READ, 8'd0, 12'd2);
    send_word(CMD_READ, 8'd0, 12'd4095);
    send_word(CMD_PUT, CH_CR, 12'd0);
    send_word(CMD_PUT, 8'd90, 12'd0);
    send_word(CMD_PUT, CH_LF, 12'd0);
    send_word(CMD_PUT, CH_BS, 12'd0);
    send_word(CMD_PUT, 8'd126, 12'd0);
    send_word(CMD_PUT, CH_CR, 12'd0);
    send_word(CMD_READ, 8'd0, 12'd0);
    send_word(CMD_READ, 8'd0, 12'd128);

    hold_req = 1'b1;
    for (int i = 0; i < 1250; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        case ($urandom_range(0, 2))
          0: addr = 12'($urandom);
          1: addr = 12'($urandom_range(3584, 4095));
          default: addr = 12'($urandom_range(0, 255));
        endcase
        send_word(CMD_READ, 8'($urandom), addr);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) ch = CH_LF;
        else if (r < 15) ch = CH_CR;
        else if (r < 18) ch = CH_BS;
        else if (r < 21) ch = CH_DEL;
        else if (r < 75) ch = 8'($urandom_range(32, 126));
        else ch = 8'($urandom);
        send_word(CMD_PUT, ch, 12'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("text_console_writer: match");
    else
      $display("text_console_writer: mismatch");
    $finish;
  end

  initial begin
    #300ms;
    $display("text_console_writer: mismatch");
    $finish;
  end

endmodule
